/* rtl/salc_pkg.sv */
package salc_pkg;

	localparam int MaxSetBits = 6;
	localparam int MaxWays = 8;
	localparam int NumSets = 1 << MaxSetBits;
	localparam int WayW = $clog2(MaxWays);
	localparam int SetW = MaxSetBits;
	localparam int TagW = 62;
	localparam int StampW = 64;
	localparam int CntW = 32;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_STORE  = 2'd1,
		OP_MODIFY = 2'd2,
		OP_IFETCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_MISS  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS       = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} bk_state_t;

	// classified access handed from front to back
	typedef struct packed {
		logic [SetW-1:0] set;
		logic [TagW-1:0] tag;
		logic            twice;
	} acc_t;

endpackage

/* rtl/salc_front.sv */
module salc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic [63:0]                  address,
	input  logic [2:0]                   set_bits_q,
	input  logic [5:0]                   block_bits_q,
	output logic                         acc_valid,
	input  logic                         acc_take,
	output salc_pkg::acc_t               acc
);

	localparam int CntW = $clog2(salc_pkg::QDepth + 1);
	localparam int PtrW = (salc_pkg::QDepth > 1) ? $clog2(salc_pkg::QDepth) : 1;

	salc_pkg::acc_t        q_mem [salc_pkg::QDepth];
	logic [PtrW-1:0]       wr_q, rd_q;
	logic [CntW-1:0]       cnt_q;
	logic [2:0]            sb;
	logic [5:0]            bb;
	logic [6:0]            sh;
	logic [63:0]           a_blk, a_tag;
	logic [63:0]           set_mask;
	salc_pkg::acc_t        cls;
	logic                  push, pop;

	always_comb begin
		sb = set_bits_q;
		if (sb == 3'd0) sb = 3'd1;
		if (sb > 3'(salc_pkg::MaxSetBits)) sb = 3'(salc_pkg::MaxSetBits);
		bb = block_bits_q;
		if (bb == 6'd0) bb = 6'd1;
		if (bb > 6'd32) bb = 6'd32;
		sh = 7'(bb) + 7'(sb);
		a_blk = address >> bb;
		a_tag = address >> sh;
		set_mask = (64'd1 << sb) - 64'd1;
		cls.set = salc_pkg::SetW'(a_blk & set_mask);
		cls.tag = a_tag[salc_pkg::TagW-1:0];
		cls.twice = (opcode == salc_pkg::OP_MODIFY);
	end

	assign in_stall = (cnt_q == CntW'(salc_pkg::QDepth));
	assign push = in_valid && !in_stall && (opcode != salc_pkg::OP_IFETCH);
	assign acc_valid = (cnt_q != '0);
	assign pop = acc_valid && acc_take;
	assign acc = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrW'(salc_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PtrW'(salc_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(salc_pkg::QDepth)) else $error("queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> !push) else $error("push while full");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop while empty");

endmodule

/* rtl/salc_back.sv */
module salc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc_valid,
	output logic                         acc_take,
	input  salc_pkg::acc_t               acc,
	input  logic [3:0]                   ways_q,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   outcome,
	output logic [31:0]                  hit_total,
	output logic [31:0]                  miss_total,
	output logic [31:0]                  eviction_total,
	output logic                         last_of_run
);

	localparam int W = salc_pkg::MaxWays;
	localparam int WW = salc_pkg::WayW;

	typedef struct packed {
		logic                        vld;
		logic [salc_pkg::TagW-1:0]   tag;
		logic [salc_pkg::StampW-1:0] stamp;
	} line_t;

	line_t                          mem [salc_pkg::NumSets][W];
	line_t                          rd_s1 [W];
	salc_pkg::bk_state_t            st_q, st_d;
	salc_pkg::acc_t                 cur_q;
	logic                           second_q;
	logic [salc_pkg::StampW-1:0]    clk_q;
	logic [salc_pkg::SetW-1:0]      clr_q;
	logic                           clr_busy_q;
	logic [3:0]                     nw;
	logic [W-1:0]                   hitv, invv;
	logic                           hit, found_inv, evict;
	logic [WW-1:0]                  hit_w, inv_w, lru_w, vic_w, wr_w;
	logic [salc_pkg::StampW-1:0]    lru_st;
	logic                           rd_en, wr_en, out_free;

	always_comb begin
		nw = ways_q;
		if (nw == 4'd0) nw = 4'd1;
		if (nw > 4'(W)) nw = 4'(W);
		hit = 1'b0;
		hit_w = '0;
		found_inv = 1'b0;
		inv_w = '0;
		lru_w = '0;
		lru_st = rd_s1[0].stamp;
		for (int w = 0; w < W; w++) begin
			hitv[w] = (4'(w) < nw) && rd_s1[w].vld && (rd_s1[w].tag == cur_q.tag);
			invv[w] = (4'(w) < nw) && !rd_s1[w].vld;
		end
		for (int w = W - 1; w >= 0; w--) begin
			if (hitv[w]) begin
				hit = 1'b1;
				hit_w = WW'(w);
			end
			if (invv[w]) begin
				found_inv = 1'b1;
				inv_w = WW'(w);
			end
		end
		for (int w = 1; w < W; w++) begin
			if ((4'(w) < nw) && (rd_s1[w].stamp < lru_st)) begin
				lru_st = rd_s1[w].stamp;
				lru_w = WW'(w);
			end
		end
		vic_w = found_inv ? inv_w : lru_w;
		evict = !hit && !found_inv;
		wr_w = hit ? hit_w : vic_w;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			salc_pkg::ST_IDLE:  if (acc_take) st_d = salc_pkg::ST_READ;
			salc_pkg::ST_READ:  st_d = salc_pkg::ST_WRITE;
			salc_pkg::ST_WRITE: if (out_free) st_d = (second_q || !cur_q.twice) ?
				salc_pkg::ST_IDLE : salc_pkg::ST_READ;
			default:            st_d = salc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		out_free = !out_valid || !out_stall;
		acc_take = (st_q == salc_pkg::ST_IDLE) && acc_valid && !clr_busy_q;
		rd_en = (st_q == salc_pkg::ST_READ);
		wr_en = (st_q == salc_pkg::ST_WRITE) && out_free;
	end

	always_ff @(posedge clk) begin
		if (acc_take) cur_q <= acc;
		if (rd_en) begin
			for (int w = 0; w < W; w++) rd_s1[w] <= mem[cur_q.set][w];
		end
		if (clr_busy_q) begin
			for (int w = 0; w < W; w++) mem[clr_q][w].vld <= 1'b0;
		end else if (wr_en) begin
			mem[cur_q.set][wr_w].vld <= 1'b1;
			mem[cur_q.set][wr_w].tag <= cur_q.tag;
			mem[cur_q.set][wr_w].stamp <= clk_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= salc_pkg::ST_IDLE;
			second_q <= 1'b0;
			clk_q <= '0;
			clr_q <= '0;
			clr_busy_q <= 1'b1;
			out_valid <= 1'b0;
			outcome <= salc_pkg::OUT_HIT;
			hit_total <= '0;
			miss_total <= '0;
			eviction_total <= '0;
			last_of_run <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == salc_pkg::SetW'(salc_pkg::NumSets - 1)) clr_busy_q <= 1'b0;
			end
			if (acc_take) second_q <= 1'b0;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (wr_en) begin
				second_q <= 1'b1;
				clk_q <= clk_q + 1'b1;
				out_valid <= 1'b1;
				last_of_run <= second_q || !cur_q.twice;
				if (hit) begin
					outcome <= salc_pkg::OUT_HIT;
					if (hit_total != '1) hit_total <= hit_total + 1'b1;
				end else begin
					outcome <= evict ? salc_pkg::OUT_EVICT : salc_pkg::OUT_MISS;
					if (miss_total != '1) miss_total <= miss_total + 1'b1;
					if (evict && eviction_total != '1)
						eviction_total <= eviction_total + 1'b1;
				end
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_clear_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !acc_take) else $error("take during clear");
	a_read_write: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> st_q == salc_pkg::ST_WRITE) else $error("read not followed by write");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc_take |-> st_q == salc_pkg::ST_IDLE) else $error("take while busy");

endmodule

/* rtl/set_assoc_lru_cache_sim.sv */
// Set-associative LRU tag store: each load or store gives one result, a modify two, an
// instruction fetch none. The back end takes the next queued item while idle, then handles
// each access as a set read followed by the compare and update of that set; a modify does
// this twice, and an update waits while the output is stalled; a two-entry queue lets the
// front keep accepting. After reset the back end clears the valid bits of all 64 sets, one
// set per cycle; transfers wait in the queue meanwhile and the input stalls once it is full.
// Lines are not flushed when configuration changes.
module set_assoc_lru_cache_sim (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  outcome,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] eviction_total,
	output logic        last_of_run
);

	logic [2:0]      set_bits_q;
	logic [5:0]      block_bits_q;
	logic [3:0]      ways_q;
	logic            acc_valid, acc_take;
	salc_pkg::acc_t  acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd1;
			block_bits_q <= 6'd1;
			ways_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				salc_pkg::CFG_SET_BITS:   set_bits_q <= cfg_data[2:0];
				salc_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data;
				salc_pkg::CFG_WAYS:       ways_q <= cfg_data[3:0];
				default:                  ;
			endcase
		end
	end

	salc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .address,
		.set_bits_q, .block_bits_q, .acc_valid, .acc_take, .acc
	);

	salc_back u_back (
		.clk, .arst_n, .acc_valid, .acc_take, .acc, .ways_q,
		.out_valid, .out_stall, .outcome, .hit_total, .miss_total,
		.eviction_total, .last_of_run
	);

endmodule

/* sim/set_assoc_lru_cache_sim_tb.sv */
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim_tb;

	localparam int NumLines = salc_pkg::NumSets * salc_pkg::MaxWays;

	typedef struct {
		salc_pkg::outcome_t outcome;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evictions;
		logic        last;
	} cache_result_t;

	class lru_scoreboard;
		logic [2:0]  set_bits_r;
		logic [5:0]  block_bits_r;
		logic [3:0]  ways_r;
		logic        valid_q [NumLines];
		logic [61:0] tag_q [NumLines];
		logic [63:0] stamp_q [NumLines];
		logic [63:0] clock_q;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evictions;
		cache_result_t pending_results[$];
		int errors;
		int checked;
		int evict_seen;

		function new();
			set_bits_r = 1;
			block_bits_r = 1;
			ways_r = 1;
			foreach (valid_q[i]) begin
				valid_q[i] = 0;
				tag_q[i] = '0;
				stamp_q[i] = '0;
			end
			clock_q = 0;
			hits = 0;
			misses = 0;
			evictions = 0;
			errors = 0;
			checked = 0;
			evict_seen = 0;
		endfunction

		function void write_reg(salc_pkg::cfg_idx_t idx, logic [5:0] v);
			case (idx)
				salc_pkg::CFG_SET_BITS: set_bits_r = v[2:0];
				salc_pkg::CFG_BLOCK_BITS: block_bits_r = v;
				salc_pkg::CFG_WAYS: ways_r = v[3:0];
				default: ;
			endcase
		endfunction

		function salc_pkg::outcome_t lookup(logic [63:0] addr);
			int sb;
			int bb;
			int nw;
			int base;
			int victim;
			logic [61:0] tg;
			logic [63:0] st;
			bit found;
			sb = set_bits_r < 1 ? 1 : (set_bits_r > salc_pkg::MaxSetBits ?
				salc_pkg::MaxSetBits : set_bits_r);
			bb = block_bits_r < 1 ? 1 : (block_bits_r > 32 ? 32 : block_bits_r);
			nw = ways_r < 1 ? 1 : (ways_r > salc_pkg::MaxWays ? salc_pkg::MaxWays : ways_r);
			tg = 62'(addr >> (sb + bb));
			st = (addr >> bb) & ((64'd1 << sb) - 1);
			base = int'(st) * salc_pkg::MaxWays;
			clock_q = clock_q + 1;
			for (int w = 0; w < nw; w++)
				if (valid_q[base+w] && tag_q[base+w] == tg) begin
					stamp_q[base+w] = clock_q;
					return salc_pkg::OUT_HIT;
				end
			victim = 0;
			found = 0;
			for (int w = 0; w < nw; w++)
				if (!found && !valid_q[base+w]) begin
					victim = w;
					found = 1;
				end
			if (!found)
				for (int w = 1; w < nw; w++)
					if (stamp_q[base+w] < stamp_q[base+victim])
						victim = w;
			found = valid_q[base+victim];
			valid_q[base+victim] = 1;
			tag_q[base+victim] = tg;
			stamp_q[base+victim] = clock_q;
			return found ? salc_pkg::OUT_EVICT : salc_pkg::OUT_MISS;
		endfunction

		function void tally(salc_pkg::outcome_t oc, logic last);
			cache_result_t r;
			if (oc == salc_pkg::OUT_HIT) begin
				if (hits != '1)
					hits++;
			end else begin
				if (misses != '1)
					misses++;
				if (oc == salc_pkg::OUT_EVICT && evictions != '1)
					evictions++;
			end
			r.outcome = oc;
			r.hits = hits;
			r.misses = misses;
			r.evictions = evictions;
			r.last = last;
			pending_results.push_back(r);
		endfunction

		function void note_access(salc_pkg::op_t op, logic [63:0] addr);
			if (op == salc_pkg::OP_IFETCH)
				return;
			if (op == salc_pkg::OP_MODIFY) begin
				tally(lookup(addr), 0);
				tally(lookup(addr), 1);
			end else
				tally(lookup(addr), 1);
		endfunction

		function void check_result(logic [1:0] oc, logic [31:0] h, logic [31:0] m,
			logic [31:0] e, logic l);
			cache_result_t r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result outcome %0d", $time, oc);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			checked++;
			if (r.outcome == salc_pkg::OUT_EVICT)
				evict_seen++;
			if (oc !== r.outcome) begin
				$display("%0t: outcome exp %0d got %0d", $time, r.outcome, oc);
				errors++;
			end
			if (h !== r.hits) begin
				$display("%0t: hit_total exp %0d got %0d", $time, r.hits, h);
				errors++;
			end
			if (m !== r.misses) begin
				$display("%0t: miss_total exp %0d got %0d", $time, r.misses, m);
				errors++;
			end
			if (e !== r.evictions) begin
				$display("%0t: eviction_total exp %0d got %0d", $time, r.evictions, e);
				errors++;
			end
			if (l !== r.last) begin
				$display("%0t: last_of_run exp %0d got %0d", $time, r.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [63:0] address;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  outcome;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] eviction_total;
	logic        last_of_run;

	lru_scoreboard sb_cache;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;
	int idle_cycles;
	int sent;

	set_assoc_lru_cache_sim u_top (.*);

	always begin
		clk = 1;
		#4;
		clk = 0;
		#4;
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb_cache.note_access(salc_pkg::op_t'(opcode), address);
		if (out_valid && !out_stall)
			sb_cache.check_result(outcome, hit_total, miss_total, eviction_total,
				last_of_run);
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (hold_off)
			out_stall <= 1;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("set_assoc_lru_cache_sim verification failed");
			$finish;
		end
	end

	task automatic send_access(salc_pkg::op_t op, logic [63:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		address <= addr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb_cache.pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_cfg(salc_pkg::cfg_idx_t idx, logic [5:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		sb_cache.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_addr(int mode);
		logic [63:0] a;
		a = {$urandom, $urandom};
		// mostly a small working set so sets fill and evict
		if (mode < 70)
			a = {54'(($urandom_range(3) == 0) ? 54'h3f_ffff_ffff_fff0 : 54'd0)
				| 54'($urandom_range(15)), 10'($urandom)};
		return a;
	endfunction

	task automatic random_phase(int n);
		salc_pkg::op_t op;
		for (int i = 0; i < n; i++) begin
			op = salc_pkg::op_t'($urandom_range(3));
			send_access(op, rand_addr($urandom_range(99)));
		end
	endtask

	initial begin
		sb_cache = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = salc_pkg::CFG_SET_BITS;
		cfg_data = 0;
		in_valid = 0;
		opcode = salc_pkg::OP_LOAD;
		address = 0;
		hold_off = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset config, every opcode, address extremes
		send_access(salc_pkg::OP_LOAD, 64'd0);
		send_access(salc_pkg::OP_LOAD, 64'd0);
		send_access(salc_pkg::OP_STORE, '1);
		send_access(salc_pkg::OP_MODIFY, 64'h8000_0000_0000_0000);
		send_access(salc_pkg::OP_IFETCH, 64'h1234);
		send_access(salc_pkg::OP_STORE, 64'h5555_5555_5555_5555);
		send_access(salc_pkg::OP_MODIFY, 64'haaaa_aaaa_aaaa_aaaa);
		send_access(salc_pkg::OP_LOAD, '1);
		drain();
		// out-of-range settings clamp
		write_cfg(salc_pkg::CFG_SET_BITS, 6'd0);
		write_cfg(salc_pkg::CFG_BLOCK_BITS, 6'd0);
		write_cfg(salc_pkg::CFG_WAYS, 6'd0);
		send_access(salc_pkg::OP_LOAD, 64'h10);
		send_access(salc_pkg::OP_LOAD, 64'h20);
		drain();
		write_cfg(salc_pkg::CFG_SET_BITS, 6'd7);
		write_cfg(salc_pkg::CFG_BLOCK_BITS, 6'd63);
		write_cfg(salc_pkg::CFG_WAYS, 6'd15);
		for (int i = 0; i < 10; i++)
			send_access(salc_pkg::OP_LOAD, {$urandom_range(9), 32'h0});
		send_access(salc_pkg::OP_MODIFY, '1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_cfg(salc_pkg::CFG_SET_BITS, 6'd1);
					write_cfg(salc_pkg::CFG_BLOCK_BITS, 6'd1);
					write_cfg(salc_pkg::CFG_WAYS, 6'd1);
				end
				1: begin
					write_cfg(salc_pkg::CFG_SET_BITS, 6'd2);
					write_cfg(salc_pkg::CFG_BLOCK_BITS, 6'd4);
					write_cfg(salc_pkg::CFG_WAYS, 6'd4);
				end
				2: begin
					write_cfg(salc_pkg::CFG_SET_BITS, 6'd6);
					write_cfg(salc_pkg::CFG_BLOCK_BITS, 6'd32);
					write_cfg(salc_pkg::CFG_WAYS, 6'd8);
				end
				3: begin
					write_cfg(salc_pkg::CFG_SET_BITS, 6'd3);
					write_cfg(salc_pkg::CFG_BLOCK_BITS, 6'd2);
					write_cfg(salc_pkg::CFG_WAYS, 6'd2);
				end
				4: write_cfg(salc_pkg::CFG_WAYS, 6'd8);
				default: begin
					write_cfg(salc_pkg::CFG_SET_BITS, 6'd1);
					write_cfg(salc_pkg::CFG_BLOCK_BITS, 6'd6);
				end
			endcase
			send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 49 : 0;
			recv_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 14 : 0;
			random_phase(150);
			if (ph == 1) begin
				hold_off = 1;
				fork
					random_phase(20);
					begin
						repeat (200) @(negedge clk);
						hold_off = 0;
					end
				join
			end
			drain();
			random_phase(150);
			drain();
		end

		$display("covered %0d transfers in, %0d results checked, %0d evictions",
			sent, sb_cache.checked, sb_cache.evict_seen);
		if (sb_cache.errors == 0 && sb_cache.pending_results.size() == 0)
			$display("set_assoc_lru_cache_sim verification clean");
		else
			$display("set_assoc_lru_cache_sim verification failed");
		$finish;
	end

endmodule
